>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge, ignored while reset is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition holds on every rising clock edge, including during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> hw/rtl/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES package
// Shared types, S-box tables and the byte-level transforms of the cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package aes_pkg;

  localparam int ROUNDS   = 10;
  localparam int NUM_RK   = ROUNDS + 1;
  localparam int RK_AW    = $clog2(NUM_RK);

  localparam logic [RK_AW-1:0] LAST_IDX = RK_AW'(ROUNDS);

  localparam logic [7:0] RCON_INIT = 8'h01;

  typedef enum logic [0:0] {
    FUNC_ENCRYPT = 1'b0,
    FUNC_DECRYPT = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_EXPAND,
    ST_IDLE,
    ST_RUN
  } state_e;

  typedef enum logic [0:0] {
    CFG_KEY_HIGH = 1'b0,
    CFG_KEY_LOW  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic        func;
    logic [63:0] data_high;
    logic [63:0] data_low;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_beat_t;

  typedef struct packed {
    logic decrypt;
    logic first;
    logic last;
  } round_ctrl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] RSBOX [256] = '{
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a block sits at bits 127-8i downto 120-8i.
  function automatic logic [7:0] get_byte(input logic [127:0] s, input int i);
    return s[127-8*i -: 8];
  endfunction

  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      r[127-8*i -: 8] = inv ? RSBOX[get_byte(s, i)] : SBOX[get_byte(s, i)];
    end
    return r;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Forward shift: out[c,r] = in[c+r,r]. Inverse: out[c+r,r] = in[c,r].
  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] r;
    int o;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        o = ((c + k) % 4) * 4 + k;
        if (inv) begin
          r[127-8*o -: 8] = get_byte(s, c*4 + k);
        end else begin
          r[127-8*(c*4+k) -: 8] = get_byte(s, o);
        end
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] w);
    logic [7:0] a0, a1, a2, a3;
    a0 = w[31:24];
    a1 = w[23:16];
    a2 = w[15:8];
    a3 = w[7:0];
    return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
            a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
            a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
            xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
  endfunction

  // Inverse column mix: coefficients 0e, 0b, 0d, 09 built from doublings.
  function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    for (int i = 0; i < 4; i++) begin
      a[i]  = w[31-8*i -: 8];
      x2[i] = xtime(a[i]);
      x4[i] = xtime(x2[i]);
      x8[i] = xtime(x4[i]);
      m9[i] = x8[i] ^ a[i];
      mb[i] = x8[i] ^ x2[i] ^ a[i];
      md[i] = x8[i] ^ x4[i] ^ a[i];
      me[i] = x8[i] ^ x4[i] ^ x2[i];
    end
    return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
            m9[0] ^ me[1] ^ mb[2] ^ md[3],
            md[0] ^ m9[1] ^ me[2] ^ mb[3],
            mb[0] ^ md[1] ^ m9[2] ^ me[3]};
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
    logic [127:0] r;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      r[127-32*c -: 32] = inv ? inv_mix_col(s[127-32*c -: 32]) : mix_col(s[127-32*c -: 32]);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/aes_round.sv
// ----------------------------------------------------------------------------
// AES round unit
// One forward or inverse cipher round per call, or the initial key addition.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_round (
  input  aes_pkg::round_ctrl_t ctrl_i,
  input  logic [127:0]         state_i,
  input  logic [127:0]         round_key_i,
  output logic [127:0]         state_o
);
  import aes_pkg::*;

  logic [127:0] enc_sr;
  logic [127:0] enc_out;
  logic [127:0] dec_ark;
  logic [127:0] dec_out;

  always_comb begin
    enc_sr  = shift_rows(sub_bytes(state_i, 1'b0), 1'b0);
    enc_out = (ctrl_i.last ? enc_sr : mix_columns(enc_sr, 1'b0)) ^ round_key_i;
    dec_ark = sub_bytes(shift_rows(state_i, 1'b1), 1'b1) ^ round_key_i;
    dec_out = ctrl_i.last ? dec_ark : mix_columns(dec_ark, 1'b1);
  end

  always_comb begin
    if (ctrl_i.first) begin
      state_o = state_i ^ round_key_i;
    end else if (ctrl_i.decrypt) begin
      state_o = dec_out;
    end else begin
      state_o = enc_out;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/aes128_block_cipher_top.sv
// ----------------------------------------------------------------------------
// AES-128 block cipher
// Encrypts or decrypts one 128-bit block at a time with a stored key schedule.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake              | Beat
//   --------+-----------+------------------------+---------------------------
//   in      | input     | in_valid_i / in_stall_o | func, data_high, data_low
//   out     | output    | out_valid_o / out_stall_i | result_high, result_low
//   cfg     | input     | cfg_we_i (no wait)      | key_high (0), key_low (1)
//
// The first round key is read at the accepting edge, then 11 passes through the
// single round unit follow, one round key read from the key memory per pass; the
// last pass goes into the output register. Each block then returns to idle, the
// only state in which a block is accepted, so a new block is not taken before
// the last one has finished. After reset, and after every key register write,
// the key schedule is rebuilt into the memory, during which no block is accepted.
// A stalled output holds the last round until the output register frees up.
//
`default_nettype none

module aes128_block_cipher_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  aes_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output aes_pkg::out_beat_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_idx_i,
  input  logic [63:0]        cfg_wdata_i
);
  import aes_pkg::*;

`include "assert_macros.svh"

  state_e            state_q, state_d;
  logic [RK_AW-1:0]  cnt_q, cnt_d;
  logic [63:0]       key_hi_q, key_lo_q;
  logic [127:0]      rk_q;
  logic [7:0]        rcon_q;
  logic [127:0]      blk_q, blk_d;
  logic              dec_q;
  logic              out_valid_q;
  out_beat_t         out_data_q;

  // Round key memory: one 128-bit round key per entry.
  logic [127:0]      rk_mem [NUM_RK];
  logic [127:0]      rk_rd_q;
  logic [RK_AW-1:0]  rd_addr;
  logic              wr_en;
  logic [127:0]      wr_data;
  logic [127:0]      next_rk;

  logic              in_accept;
  logic              finish;
  logic              out_free;
  round_ctrl_t       rctrl;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign finish    = (state_q == ST_RUN) && (cnt_q == LAST_IDX) && out_free;

  // Next round key from the previous one.
  always_comb begin
    logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3;
    w0 = rk_q[127:96];
    w1 = rk_q[95:64];
    w2 = rk_q[63:32];
    w3 = rk_q[31:0];
    t  = sub_word({w3[23:0], w3[31:24]}) ^ {rcon_q, 24'h0};
    n0 = w0 ^ t;
    n1 = w1 ^ n0;
    n2 = w2 ^ n1;
    n3 = w3 ^ n2;
    next_rk = {n0, n1, n2, n3};
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    if (cfg_we_i) begin
      state_d = ST_EXPAND;
      cnt_d   = '0;
    end else begin
      case (state_q)
        ST_EXPAND: begin
          if (cnt_q == LAST_IDX) begin
            state_d = ST_IDLE;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            state_d = ST_RUN;
            cnt_d   = '0;
          end
        end
        ST_RUN: begin
          if (cnt_q != LAST_IDX) begin
            cnt_d = cnt_q + 1'b1;
          end else if (out_free) begin
            state_d = ST_IDLE;
            cnt_d   = '0;
          end
        end
        default: begin
          state_d = ST_EXPAND;
          cnt_d   = '0;
        end
      endcase
    end
  end

  // Outputs of the sequencer.
  always_comb begin
    in_stall_o = 1'b1;
    wr_en      = 1'b0;
    wr_data    = next_rk;
    rd_addr    = '0;
    case (state_q)
      ST_EXPAND: begin
        wr_en   = 1'b1;
        wr_data = (cnt_q == '0) ? {key_hi_q, key_lo_q} : next_rk;
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        rd_addr    = (in_data_i.func == FUNC_DECRYPT) ? LAST_IDX : '0;
      end
      ST_RUN: begin
        // Fetch the key for the following round; decryption walks downward.
        // In the last round the current key is read again so that it stays
        // in place while the output is stalled.
        if (cnt_q != LAST_IDX) begin
          rd_addr = dec_q ? (LAST_IDX - cnt_q - 1'b1) : (cnt_q + 1'b1);
        end else begin
          rd_addr = dec_q ? '0 : LAST_IDX;
        end
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  assign rctrl.decrypt = dec_q;
  assign rctrl.first   = (cnt_q == '0);
  assign rctrl.last    = (cnt_q == LAST_IDX);

  aes_round u_round (
    .ctrl_i      (rctrl),
    .state_i     (blk_q),
    .round_key_i (rk_rd_q),
    .state_o     (blk_d)
  );

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      rk_mem[cnt_q] <= wr_data;
    end
    rk_rd_q <= rk_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_EXPAND;
      cnt_q       <= '0;
      key_hi_q    <= '0;
      key_lo_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i && (cfg_idx_i == CFG_KEY_HIGH)) begin
        key_hi_q <= cfg_wdata_i;
      end
      if (cfg_we_i && (cfg_idx_i == CFG_KEY_LOW)) begin
        key_lo_q <= cfg_wdata_i;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXPAND) begin
      rk_q   <= wr_data;
      rcon_q <= (cnt_q == '0) ? RCON_INIT : xtime(rcon_q);
    end
    if (in_accept) begin
      blk_q <= {in_data_i.data_high, in_data_i.data_low};
      dec_q <= in_data_i.func;
    end else if ((state_q == ST_RUN) && (cnt_q != LAST_IDX)) begin
      blk_q <= blk_d;
    end
    if (finish) begin
      out_data_q.result_high <= blk_d[127:64];
      out_data_q.result_low  <= blk_d[63:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `ASSERT_CLK(a_accept_starts_run, in_accept && !cfg_we_i |=> state_q == ST_RUN && cnt_q == '0,
              "accepted block did not start at the first round")
  `ASSERT_CLK(a_no_accept_in_expand, state_q == ST_EXPAND |-> in_stall_o,
              "block accepted while the key schedule is rebuilt")
  `ASSERT_CLK(a_finish_needs_room, finish |-> !out_valid_q || !out_stall_i,
              "result overwrote a waiting output beat")
  `ASSERT_ALWAYS(a_write_only_expand, wr_en |-> state_q == ST_EXPAND,
                 "key memory written outside key expansion")

endmodule

`default_nettype wire

>>> tb/aes_cipher_checker.sv
// ----------------------------------------------------------------------------
// AES-128 result checker
// Watches the block and key ports, computes each expected result block with an
// independent cipher model and compares it with the beats the block returns.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_cipher_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  aes_pkg::in_beat_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  aes_pkg::out_beat_t out_data_i,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_idx_i,
  input  logic [63:0]        cfg_wdata_i,
  output int                 fail_cnt_o,
  output int                 pending_o,
  output int                 enc_cnt_o,
  output int                 dec_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import aes_pkg::*;

  logic [7:0]  fwd_sbox [256];
  logic [7:0]  rev_sbox [256];
  logic [63:0] cur_key_hi, cur_key_lo;
  logic [31:0] sched [44];
  out_beat_t   expected_blocks [$];

  function automatic logic [7:0] dbl(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = dbl(a);
    end
    return p;
  endfunction

  // S-boxes are derived from the field inverse, not copied from a table.
  initial begin
    logic [7:0] inv, s;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h01;
      for (int k = 0; k < 254; k++) inv = gf_mul(inv, 8'(x));
      if (x == 0) inv = 8'h00;
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      fwd_sbox[x] = s;
      rev_sbox[s] = 8'(x);
    end
  end

  task automatic rebuild_schedule();
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    sched[0] = cur_key_hi[63:32];
    sched[1] = cur_key_hi[31:0];
    sched[2] = cur_key_lo[63:32];
    sched[3] = cur_key_lo[31:0];
    for (int i = 4; i < 44; i++) begin
      t = sched[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {fwd_sbox[t[31:24]], fwd_sbox[t[23:16]], fwd_sbox[t[15:8]], fwd_sbox[t[7:0]]}
            ^ {rc, 24'h0};
        rc = dbl(rc);
      end
      sched[i] = sched[i-4] ^ t;
    end
  endtask

  // State byte i sits at st[i]; column c holds bytes 4c..4c+3.
  function automatic out_beat_t cipher_block(input in_beat_t b);
    logic [7:0]   st [16];
    logic [7:0]   tmp [16];
    logic [7:0]   col [4];
    logic [7:0]   fc [4];
    logic [7:0]   ic [4];
    logic [7:0]   v;
    logic [127:0] blk;
    out_beat_t    r;
    int           rnd;
    fc = '{8'h02, 8'h03, 8'h01, 8'h01};
    ic = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    blk = {b.data_high, b.data_low};
    for (int i = 0; i < 16; i++) st[i] = blk[127-8*i -: 8];
    for (int step = 0; step <= 10; step++) begin
      rnd = (b.func == FUNC_DECRYPT) ? 10 - step : step;
      if (step > 0) begin
        for (int c = 0; c < 4; c++) begin
          for (int k = 0; k < 4; k++) begin
            if (b.func == FUNC_DECRYPT) tmp[((c + k) % 4) * 4 + k] = st[c*4+k];
            else tmp[c*4+k] = st[((c + k) % 4) * 4 + k];
          end
        end
        for (int i = 0; i < 16; i++) begin
          st[i] = (b.func == FUNC_DECRYPT) ? rev_sbox[tmp[i]] : fwd_sbox[tmp[i]];
        end
        if (b.func == FUNC_ENCRYPT && step < 10) begin
          for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) col[k] = st[c*4+k];
            for (int rr = 0; rr < 4; rr++) begin
              v = 8'h00;
              for (int k = 0; k < 4; k++) v ^= gf_mul(fc[(k - rr + 4) % 4], col[k]);
              st[c*4+rr] = v;
            end
          end
        end
      end
      for (int c = 0; c < 4; c++) begin
        for (int k = 0; k < 4; k++) st[c*4+k] ^= sched[rnd*4+c][31-8*k -: 8];
      end
      // The inverse cipher unmixes after each key addition except the first and the last.
      if (b.func == FUNC_DECRYPT && step > 0 && step < 10) begin
        for (int c = 0; c < 4; c++) begin
          for (int k = 0; k < 4; k++) col[k] = st[c*4+k];
          for (int rr = 0; rr < 4; rr++) begin
            v = 8'h00;
            for (int k = 0; k < 4; k++) v ^= gf_mul(ic[(k - rr + 4) % 4], col[k]);
            st[c*4+rr] = v;
          end
        end
      end
    end
    for (int i = 0; i < 8; i++) begin
      r.result_high[63-8*i -: 8] = st[i];
      r.result_low[63-8*i -: 8]  = st[8+i];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t exp_b;
    if (!rst_ni) begin
      cur_key_hi = '0;
      cur_key_lo = '0;
      rebuild_schedule();
      expected_blocks.delete();
      fail_cnt_o = 0;
      pending_o = 0;
      enc_cnt_o = 0;
      dec_cnt_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_blocks.size() == 0) begin
          $error("result beat with nothing expected: %h", out_data_i);
          fail_cnt_o++;
        end else begin
          exp_b = expected_blocks.pop_front();
          if (out_data_i.result_high !== exp_b.result_high) begin
            $error("result_high expected %h actual %h", exp_b.result_high,
                   out_data_i.result_high);
            fail_cnt_o++;
          end
          if (out_data_i.result_low !== exp_b.result_low) begin
            $error("result_low expected %h actual %h", exp_b.result_low,
                   out_data_i.result_low);
            fail_cnt_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_blocks.insert(expected_blocks.size(), cipher_block(in_data_i));
        if (in_data_i.func == FUNC_DECRYPT) dec_cnt_o++;
        else enc_cnt_o++;
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_KEY_HIGH) cur_key_hi = cfg_wdata_i;
        else cur_key_lo = cfg_wdata_i;
        rebuild_schedule();
      end
      pending_o = expected_blocks.size();
    end
  end

endmodule

`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// AES-128 block cipher testbench
// Drives blocks under several keys with random gaps and output stalls; the
// checker predicts every result and counts mismatches for the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aes_pkg::*;

  localparam int  RANDOM_BEATS = 1430;
  localparam int  CYCLE_LIMIT  = 400000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_beat = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_beat;
  logic      cfg_we = 1'b0;
  logic [0:0] cfg_idx = CFG_KEY_HIGH;
  logic [63:0] cfg_wdata = '0;
  int        fail_cnt, pending, enc_cnt, dec_cnt;
  int        cycle_cnt = 0;
  bit        stalls_on = 1'b1;

  // Clock: 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  aes128_block_cipher_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_beat),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_beat),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  aes_cipher_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_data_i  (in_beat),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_data_i (out_beat),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending),
    .enc_cnt_o  (enc_cnt),
    .dec_cnt_o  (dec_cnt)
  );

  // Mostly no gap, sometimes a short one, now and then a long one.
  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(15, 60);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // The receiver stalls at random, at times in long runs. Stalls can be
  // switched off for stretches.
  always @(posedge clk_i) begin
    if (!stalls_on) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 99) < 4) begin
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < 30) begin
      out_stall <= ($urandom_range(0, 2) == 0);
    end
  end

  // Safety net: the slowest correct run stays far below this.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // One beat: hold valid and payload until the block takes it. Valid is
  // dropped only when a gap follows, so back-to-back beats keep it high.
  task automatic send_block(input func_e f, input logic [63:0] hi, input logic [63:0] lo);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_beat  <= '{func: f, data_high: hi, data_low: lo};
    do @(posedge clk_i); while (in_stall);
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
  endtask

  // Key registers change only when the block is idle: every result back,
  // then enough cycles for the last block to leave the round unit.
  task automatic drain();
    pause_until_drained();
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_key(input cfg_idx_e idx, input logic [63:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Data word with a bias toward all-zero, all-one and single-bit patterns.
  function automatic logic [63:0] pick_data();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 64'h1 << $urandom_range(0, 63);
      default: return rand64();
    endcase
  endfunction

  initial begin
    logic [63:0] hi, lo;
    func_e       f;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. The reset key schedule (all-zero key) is used first.
    send_block(FUNC_ENCRYPT, '0, '0);
    send_block(FUNC_DECRYPT, '0, '0);
    send_block(FUNC_ENCRYPT, '1, '1);
    send_block(FUNC_DECRYPT, '1, '1);
    // Standard test vector key, then its plaintext both ways.
    write_key(CFG_KEY_HIGH, 64'h0001020304050607);
    // Only one half written: the block must combine it with the old low half.
    send_block(FUNC_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
    write_key(CFG_KEY_LOW, 64'h08090a0b0c0d0e0f);
    send_block(FUNC_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(FUNC_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    send_block(FUNC_ENCRYPT, 64'h8000000000000000, 64'h0000000000000001);
    send_block(FUNC_DECRYPT, 64'h0000000000000001, 64'h8000000000000000);
    write_key(CFG_KEY_HIGH, '1);
    write_key(CFG_KEY_LOW, '1);
    send_block(FUNC_ENCRYPT, '0, '1);
    send_block(FUNC_DECRYPT, '1, '0);
    send_block(FUNC_ENCRYPT, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    // One more decrypt, then a full pause until drained.
    send_block(FUNC_DECRYPT, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    pause_until_drained();

    // Random part, in phases under fresh keys; each phase starts idle.
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 180 == 0) begin
        stalls_on = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 3))
          0: write_key(CFG_KEY_HIGH, rand64());
          1: write_key(CFG_KEY_LOW, rand64());
          2: begin
            write_key(CFG_KEY_HIGH, pick_data());
            write_key(CFG_KEY_LOW, pick_data());
          end
          default: begin
            write_key(CFG_KEY_HIGH, rand64());
            write_key(CFG_KEY_LOW, rand64());
          end
        endcase
      end
      if (n == 700) pause_until_drained();
      f  = func_e'($urandom_range(0, 1));
      hi = pick_data();
      lo = pick_data();
      send_block(f, hi, lo);
    end

    stalls_on = 1'b1;
    pause_until_drained();
    repeat (20) @(posedge clk_i);
    $display("covered %0d encrypt and %0d decrypt blocks under several keys,",
             enc_cnt, dec_cnt);
    $display("with random input gaps and output stalls");
    if (fail_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
+incdir+hw/rtl
hw/rtl/aes_pkg.sv
hw/rtl/aes_round.sv
hw/rtl/aes128_block_cipher_top.sv
tb/aes_cipher_checker.sv
tb/tb.sv
